// ----- rtl/core/tnct_pkg.sv -----
// ----------------------------------------------------------------------------
// tnct_pkg
// Shared types and request codes for the name cache table with TTL aging.
// ----------------------------------------------------------------------------
package tnct_pkg;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] addr;
        logic [31:0] ttl;
    } t_entry;

    typedef struct packed {
        logic mem_we;
        logic live_we;
        logic live_d;
    } t_wr_ctl;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// ----- rtl/core/ttl_name_cache_table.sv -----
// ----------------------------------------------------------------------------
// ttl_name_cache_table
// Cache of name keys to IPv4 addresses with lookup, insert and TTL aging.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (i_in_valid / o_in_ready) and each
// one yields exactly one result on the output channel (o_out_valid /
// i_out_ready). A request is a lookup, an insert or an aging tick; code 3
// is ignored and returns an all-zero result. Every lookup, insert or tick
// sweeps the whole entry memory through its single read port, one slot
// per cycle; an insert then writes its chosen slot after the sweep. The
// next request can be taken in the same cycle as its result enters the
// output register.
// Ticks write back decremented TTLs during the sweep itself.
// One request is in progress at a time; a new request is taken as soon as
// the previous result sits in the output register, even if it is stalled.
// A result waits in the output register until the receiver takes it.
// Reset clears the slot occupancy flags at once, so every slot is free in
// the first cycle after reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
module ttl_name_cache_table
    import tnct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_name_key,
    input  logic [31:0] i_addr_in,
    input  logic [31:0] i_ttl_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic [31:0] o_addr_out,
    output logic [3:0]  o_slot,
    output logic        o_evicted,
    output logic [4:0]  o_freed_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_req;
    logic [63:0]        r_key;
    logic [31:0]        r_addr;
    logic [31:0]        r_ttl;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_issue;
    logic               r_dv;
    logic [IDX_W-1:0]   r_dv_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [31:0]        r_hit_addr;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_vic_set;
    logic [IDX_W-1:0]   r_vic_idx;
    logic [31:0]        r_vic_ttl;
    logic [CNT_W-1:0]   r_freed;
    logic [IDX_W-1:0]   r_tgt;
    logic               r_evict;
    logic               r_out_valid;
    logic               r_o_hit;
    logic [31:0]        r_o_addr;
    logic [3:0]         r_o_slot;
    logic               r_o_evicted;
    logic [4:0]         r_o_freed;

    t_entry             w_rd_entry;
    logic               w_rd_live;
    t_wr_ctl            w_wr_ctl;
    logic [IDX_W-1:0]   w_wr_idx;
    t_entry             w_wr_entry;
    logic               w_accept;
    logic               w_proc;
    logic               w_last;
    logic               w_out_free;
    logic               w_tick_free;

    tnct_store #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (r_issue),
        .i_rd_idx   (r_rd_idx),
        .o_rd_entry (w_rd_entry),
        .o_rd_live  (w_rd_live),
        .i_wr_ctl   (w_wr_ctl),
        .i_wr_idx   (w_wr_idx),
        .i_wr_entry (w_wr_entry)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_proc      = (r_state == S_SCAN) && r_dv;
    assign w_last      = w_proc && (r_dv_idx == LAST_IDX);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_tick_free = w_rd_live && (w_rd_entry.ttl <= 32'd1);

    always_comb begin
        w_wr_ctl   = '0;
        w_wr_idx   = r_dv_idx;
        w_wr_entry = w_rd_entry;
        if (w_proc && (r_req == REQ_TICK) && w_rd_live) begin
            w_wr_entry.ttl   = w_rd_entry.ttl - 32'd1;
            w_wr_ctl.mem_we  = !w_tick_free;
            w_wr_ctl.live_we = w_tick_free;
            w_wr_ctl.live_d  = 1'b0;
        end else if (r_state == S_WRITE) begin
            w_wr_idx         = r_tgt;
            w_wr_entry.key   = r_key;
            w_wr_entry.addr  = r_addr;
            w_wr_entry.ttl   = r_ttl;
            w_wr_ctl.mem_we  = 1'b1;
            w_wr_ctl.live_we = 1'b1;
            w_wr_ctl.live_d  = (r_addr != 32'd0);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_LOOKUP || i_req_type == REQ_INSERT ||
                        i_req_type == REQ_TICK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = (r_req == REQ_INSERT) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= r_issue;
            if (w_accept) begin
                r_issue <= (n_state == S_SCAN);
            end else if (r_issue && (r_rd_idx == LAST_IDX)) begin
                r_issue <= 1'b0;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_idx <= r_rd_idx;
        if (w_accept) begin
            r_req        <= i_req_type;
            r_key        <= i_name_key;
            r_addr       <= i_addr_in;
            r_ttl        <= i_ttl_in;
            r_rd_idx     <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
            r_hit_addr   <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_vic_set    <= 1'b0;
            r_vic_idx    <= '0;
            r_vic_ttl    <= '0;
            r_freed      <= '0;
            r_tgt        <= '0;
            r_evict      <= 1'b0;
        end else begin
            if (r_issue) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (w_proc) begin
                case (r_req)
                    REQ_LOOKUP: begin
                        if (!r_hit && w_rd_live && (w_rd_entry.key == r_key)) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_dv_idx;
                            r_hit_addr <= w_rd_entry.addr;
                        end
                    end
                    REQ_INSERT: begin
                        if (!r_free_found) begin
                            if (!w_rd_live) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_dv_idx;
                            end else if (!r_vic_set || (w_rd_entry.ttl < r_vic_ttl)) begin
                                r_vic_set <= 1'b1;
                                r_vic_idx <= r_dv_idx;
                                r_vic_ttl <= w_rd_entry.ttl;
                            end
                        end
                    end
                    REQ_TICK: begin
                        if (w_tick_free) begin
                            r_freed <= r_freed + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (w_last && (r_req == REQ_INSERT)) begin
                if (r_free_found) begin
                    r_tgt   <= r_free_idx;
                    r_evict <= 1'b0;
                end else if (!w_rd_live) begin
                    r_tgt   <= r_dv_idx;
                    r_evict <= 1'b0;
                end else if (!r_vic_set || (w_rd_entry.ttl < r_vic_ttl)) begin
                    r_tgt   <= r_dv_idx;
                    r_evict <= 1'b1;
                end else begin
                    r_tgt   <= r_vic_idx;
                    r_evict <= 1'b1;
                end
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_o_hit     <= r_hit;
            r_o_addr    <= r_hit_addr;
            r_o_slot    <= (r_req == REQ_INSERT) ? 4'(r_tgt) : 4'(r_hit_idx);
            r_o_evicted <= r_evict;
            r_o_freed   <= 5'(r_freed);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_addr_out    = r_o_addr;
    assign o_slot        = r_o_slot;
    assign o_evicted     = r_o_evicted;
    assign o_freed_count = r_o_freed;

endmodule

// ----- rtl/core/tnct_store.sv -----
// ----------------------------------------------------------------------------
// tnct_store
// Entry memory with one registered read port and one write port, plus a
// flip-flop per slot that marks the slot as holding a nonzero address.
// ----------------------------------------------------------------------------
module tnct_store
    import tnct_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_entry,
    output logic             o_rd_live,
    input  t_wr_ctl          i_wr_ctl,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_entry
);

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_live;
    t_entry             r_rd_entry;
    logic               r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.mem_we) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_idx];
            r_rd_live  <= r_live[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (i_wr_ctl.live_we) begin
            r_live[i_wr_idx] <= i_wr_ctl.live_d;
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_live  = r_rd_live;

endmodule
